>>> rtl/nfds_pkg.sv
// ----------------------------------------------------------------------------
// nfds_pkg
// Shared types and constants for the nonuniform three-point stencil generator.
// ----------------------------------------------------------------------------
package nfds_pkg;

	localparam int LOC_W          = 32;
	localparam int COEFF_W        = 48;
	localparam int IDX_W          = 12;
	localparam int ORDER_W        = 2;
	localparam int MAX_POINTS_DEF = 4096;

	// quotient bits below the overflow pre-check
	localparam int DIV_BITS = 49;
	localparam int DEN_W    = 64;
	localparam int NUM_W    = 64;

	localparam logic [ORDER_W-1:0] ORDER_RESET  = 2'd1;
	localparam logic [ORDER_W-1:0] ORDER_SECOND = 2'd2;

	localparam logic [DIV_BITS-1:0] MAG_CAP     = 49'h1_0000_0000_0000;
	localparam logic [DIV_BITS-1:0] MAG_POS_MAX = 49'h0_7FFF_FFFF_FFFF;
	localparam logic [DIV_BITS-1:0] MAG_NEG_MAX = 49'h0_8000_0000_0000;
	localparam logic [COEFF_W-1:0]  COEFF_POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [COEFF_W-1:0]  COEFF_NEG_MAX = 48'h8000_0000_0000;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_ORDER    = 2'd1,
		STATUS_SHORT    = 2'd2,
		STATUS_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SEL_LOWER = 2'd0,
		SEL_DIAG  = 2'd1,
		SEL_UPPER = 2'd2
	} coeff_sel_t;

	typedef struct packed {
		logic             capture;
		logic             take;
		logic             load_den;
		logic             div_init;
		logic             div_step;
		logic             div_finish;
		coeff_sel_t       sel;
		logic             emit;
		status_t          status;
		logic [IDX_W-1:0] row_idx;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic loc_le_newer;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/nonuniform_fd_stencil_gen_top.sv
// ----------------------------------------------------------------------------
// nonuniform_fd_stencil_gen_top
// Three-point first/second derivative stencil rows on a nonuniform grid.
//
//   channel   direction   handshake              payload
//   in        in          in_valid / in_ready    location, first_point, final_point
//   out       out         out_valid / out_ready  row_index, *_coeff, saturated,
//                                                status, last_row
//   cfg       in          cfg_we                 cfg_wdata (derivative_order)
//
// A row passes through one decide step, then per coefficient one multiply,
// one divider set-up, 49 restoring steps and one round/saturate step in the
// shared divider, then the load of the result register. Ignored requests
// return to idle from the decide step; error results go to the emit step.
// Reset is asynchronous; no clearing pass is needed.
// A stalled result holds the block in its emit step; the next request is
// taken as soon as the result register has been loaded.
// ----------------------------------------------------------------------------
module nonuniform_fd_stencil_gen_top import nfds_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ORDER_W-1:0]        cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [LOC_W-1:0]   location,
	input  logic                      first_point,
	input  logic                      final_point,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [IDX_W-1:0]          row_index,
	output logic signed [COEFF_W-1:0] lower_coeff,
	output logic signed [COEFF_W-1:0] diagonal_coeff,
	output logic signed [COEFF_W-1:0] upper_coeff,
	output logic                      saturated,
	output logic [1:0]                status,
	output logic                      last_row
);

	cmd_t  cmd;
	stat_t st;
	logic  last_q;

	nfds_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.first_point(first_point),
		.final_point(final_point),
		.st         (st),
		.cmd        (cmd)
	);

	nfds_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.location      (location),
		.cmd           (cmd),
		.st            (st),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.row_index     (row_index),
		.lower_coeff   (lower_coeff),
		.diagonal_coeff(diagonal_coeff),
		.upper_coeff   (upper_coeff),
		.saturated     (saturated),
		.status        (status)
	);

	always_ff @(posedge clk) begin
		if (cmd.emit) last_q <= cmd.last;
	end

	assign last_row = last_q;

endmodule

>>> rtl/nfds_ctrl.sv
// ----------------------------------------------------------------------------
// nfds_ctrl
// Sequencer: grid bookkeeping, error decisions and the divider schedule.
// ----------------------------------------------------------------------------
module nfds_ctrl import nfds_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  first_point,
	input  logic  final_point,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam int CNT_W     = $clog2(MAX_POINTS + 1);
	localparam int IDX_EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int ITER_W    = $clog2(DIV_BITS);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECIDE = 7'b0000010,
		S_DEN    = 7'b0000100,
		S_INIT   = 7'b0001000,
		S_ITER   = 7'b0010000,
		S_FINISH = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic              failed_q;
	logic              first_q, final_q;
	status_t           status_q;
	logic [IDX_W-1:0]  row_idx_q;
	logic              last_q;
	coeff_sel_t        sel_q;
	logic [ITER_W-1:0] iter_q;

	logic [CNT_W-1:0]     cnt_eff;
	logic                 failed_eff;
	logic [IDX_EXT_W-1:0] row_ext;
	logic                 accept;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign cnt_eff    = first_q ? '0 : count_q;
	assign failed_eff = first_q ? 1'b0 : failed_q;
	assign row_ext    = IDX_EXT_W'(cnt_eff) - IDX_EXT_W'(1);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.capture    = accept;
		cmd.sel        = sel_q;
		cmd.status     = status_q;
		cmd.row_idx    = row_idx_q;
		cmd.last       = last_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (failed_eff) begin
					state_d = S_IDLE;
				end else if (cnt_eff >= CNT_W'(MAX_POINTS)) begin
					state_d = S_EMIT;
				end else if (cnt_eff >= CNT_W'(1) && st.loc_le_newer) begin
					state_d = S_EMIT;
				end else begin
					cmd.take = 1'b1;
					if (cnt_eff >= CNT_W'(2)) state_d = S_DEN;
					else if (final_q) state_d = S_EMIT;
					else state_d = S_IDLE;
				end
			end
			S_DEN: begin
				cmd.load_den = 1'b1;
				state_d      = S_INIT;
			end
			S_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_ITER;
			end
			S_ITER: begin
				cmd.div_step = 1'b1;
				if (iter_q == ITER_W'(DIV_BITS - 1)) state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.div_finish = 1'b1;
				if (sel_q == SEL_UPPER) state_d = S_EMIT;
				else state_d = S_DEN;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			failed_q  <= 1'b0;
			first_q   <= 1'b0;
			final_q   <= 1'b0;
			status_q  <= STATUS_OK;
			row_idx_q <= '0;
			last_q    <= 1'b0;
			sel_q     <= SEL_LOWER;
			iter_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				first_q <= first_point;
				final_q <= final_point;
			end
			case (state_q)
				S_DECIDE: begin
					count_q  <= cnt_eff;
					failed_q <= failed_eff;
					sel_q    <= SEL_LOWER;
					if (!failed_eff) begin
						if (cnt_eff >= CNT_W'(MAX_POINTS)) begin
							failed_q  <= 1'b1;
							status_q  <= STATUS_OVERFLOW;
							row_idx_q <= '0;
							last_q    <= 1'b1;
						end else if (cnt_eff >= CNT_W'(1) && st.loc_le_newer) begin
							failed_q  <= 1'b1;
							status_q  <= STATUS_ORDER;
							row_idx_q <= '0;
							last_q    <= 1'b1;
						end else begin
							count_q  <= cnt_eff + CNT_W'(1);
							failed_q <= final_q;
							if (cnt_eff >= CNT_W'(2)) begin
								status_q  <= STATUS_OK;
								row_idx_q <= row_ext[IDX_W-1:0];
								last_q    <= final_q;
							end else begin
								status_q  <= STATUS_SHORT;
								row_idx_q <= '0;
								last_q    <= 1'b1;
							end
						end
					end
				end
				S_INIT:   iter_q <= '0;
				S_ITER:   iter_q <= iter_q + ITER_W'(1);
				S_FINISH: begin
					case (sel_q)
						SEL_LOWER: sel_q <= SEL_DIAG;
						SEL_DIAG:  sel_q <= SEL_UPPER;
						default:   sel_q <= SEL_LOWER;
					endcase
				end
				default: ;
			endcase
		end
	end

	// assertions
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result loaded over an untaken one");

	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DECIDE)
		else $error("accepted request not decided next");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ITER |-> iter_q < ITER_W'(DIV_BITS))
		else $error("divider step count out of range");

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEN || state_q == S_FINISH) |-> sel_q != 2'd3)
		else $error("coefficient select out of range");

endmodule

>>> rtl/nfds_datapath.sv
// ----------------------------------------------------------------------------
// nfds_datapath
// Location store, differences, shared multiplier, restoring divider and
// the result register.
// ----------------------------------------------------------------------------
module nfds_datapath import nfds_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ORDER_W-1:0]        cfg_wdata,
	input  logic signed [LOC_W-1:0]   location,
	input  cmd_t                      cmd,
	output stat_t                     st,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [IDX_W-1:0]          row_index,
	output logic signed [COEFF_W-1:0] lower_coeff,
	output logic signed [COEFF_W-1:0] diagonal_coeff,
	output logic signed [COEFF_W-1:0] upper_coeff,
	output logic                      saturated,
	output logic [1:0]                status
);

	logic [ORDER_W-1:0]      order_q;
	logic signed [LOC_W-1:0] loc_q, older_q, newer_q;
	logic [LOC_W-1:0]        dxl_q, dxu_q, dxm_q;
	logic [DEN_W-1:0]        den_q;
	logic [NUM_W-1:0]        num_q;
	logic                    neg_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DIV_BITS-1:0]     shift_q, quo_q;
	logic                    ovf_q;
	logic [COEFF_W-1:0]      coeff_q [3];
	logic                    sat_q;
	logic                    out_valid_q;

	logic                    second;
	logic                    neg_diag;
	logic [LOC_W-1:0]        mul_a, mul_b, num_a;
	logic                    sign_d;
	logic [NUM_W-1:0]        num_d;
	logic [DEN_W:0]          trial;
	logic                    round_up;
	logic [DIV_BITS:0]       q_round;
	logic [DIV_BITS-1:0]     mag;
	logic [COEFF_W-1:0]      coeff_d;
	logic                    sat_d;

	assign second   = (order_q == ORDER_SECOND);
	assign neg_diag = dxu_q < dxl_q;

	assign st.loc_le_newer = loc_q <= newer_q;
	assign st.out_free     = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.sel)
			SEL_LOWER: begin
				mul_a  = dxl_q;
				mul_b  = dxm_q;
				num_a  = dxu_q;
				sign_d = !second;
			end
			SEL_DIAG: begin
				mul_a  = dxl_q;
				mul_b  = dxu_q;
				num_a  = neg_diag ? (dxl_q - dxu_q) : (dxu_q - dxl_q);
				sign_d = second || neg_diag;
			end
			default: begin
				mul_a  = dxu_q;
				mul_b  = dxm_q;
				num_a  = dxl_q;
				sign_d = 1'b0;
			end
		endcase
		num_d = second ? (NUM_W'(1) << DIV_BITS) : {num_a, 32'd0};
	end

	assign trial = {rem_q, shift_q[DIV_BITS-1]} - {1'b0, den_q};

	always_comb begin
		round_up = {rem_q, 1'b0} >= {1'b0, den_q};
		q_round  = {1'b0, quo_q} + (DIV_BITS + 1)'(round_up);
		if (ovf_q || q_round > {1'b0, MAG_CAP}) mag = MAG_CAP;
		else mag = q_round[DIV_BITS-1:0];
		sat_d = 1'b0;
		if (neg_q) begin
			if (mag > MAG_NEG_MAX) begin
				sat_d   = 1'b1;
				coeff_d = COEFF_NEG_MAX;
			end else begin
				coeff_d = COEFF_W'(0) - mag[COEFF_W-1:0];
			end
		end else begin
			if (mag > MAG_POS_MAX) begin
				sat_d   = 1'b1;
				coeff_d = COEFF_POS_MAX;
			end else begin
				coeff_d = mag[COEFF_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q     <= ORDER_RESET;
			older_q     <= '0;
			newer_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) order_q <= cfg_wdata;
			if (cmd.take) begin
				older_q <= newer_q;
				newer_q <= loc_q;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) loc_q <= location;
		if (cmd.take) begin
			dxl_q <= LOC_W'(newer_q - older_q);
			dxu_q <= LOC_W'(loc_q - newer_q);
			dxm_q <= LOC_W'(loc_q - older_q);
			sat_q <= 1'b0;
		end
		if (cmd.load_den) begin
			den_q <= {32'd0, mul_a} * {32'd0, mul_b};
			num_q <= num_d;
			neg_q <= sign_d;
		end
		if (cmd.div_init) begin
			ovf_q   <= {49'd0, num_q[NUM_W-1:DIV_BITS]} >= den_q;
			rem_q   <= {49'd0, num_q[NUM_W-1:DIV_BITS]};
			shift_q <= num_q[DIV_BITS-1:0];
			quo_q   <= '0;
		end
		if (cmd.div_step) begin
			shift_q <= {shift_q[DIV_BITS-2:0], 1'b0};
			if (!trial[DEN_W]) begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DEN_W-2:0], shift_q[DIV_BITS-1]};
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
		if (cmd.div_finish) begin
			sat_q <= sat_q | sat_d;
			case (cmd.sel)
				SEL_LOWER: coeff_q[0] <= coeff_d;
				SEL_DIAG:  coeff_q[1] <= coeff_d;
				default:   coeff_q[2] <= coeff_d;
			endcase
		end
		if (cmd.emit) begin
			row_index <= cmd.row_idx;
			status    <= cmd.status;
			if (cmd.status == STATUS_OK) begin
				lower_coeff    <= coeff_q[0];
				diagonal_coeff <= coeff_q[1];
				upper_coeff    <= coeff_q[2];
				saturated      <= sat_q;
			end else begin
				lower_coeff    <= '0;
				diagonal_coeff <= '0;
				upper_coeff    <= '0;
				saturated      <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
